[rtl/core/button_debounce_triple_press_assert.svh]
// ----------------------------------------------------------------------------
// Button debounce triple press assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_TRIPLE_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_TRIPLE_PRESS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BD3P_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BD3P_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bd3p_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce triple press package
// Shared constants, register codes and status types of the block.
// ----------------------------------------------------------------------------
package bd3p_pkg;

    localparam int NUM_BUTTONS_DEF = 3;
    localparam int TIME_BITS_DEF   = 32;

    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_BITS   = 3;
    localparam int COUNT_W    = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;
    localparam logic [COUNT_W-1:0] TRIPLE_COUNT = 8'd3;

    // Raw level, stable level and pending flag, plus the press count.
    localparam int ENTRY_FIXED_W = 3 + COUNT_W;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] GAP_RESET      = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd500;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_MIN_GAP  = 2'd1,
        REG_WINDOW   = 2'd2
    } cfg_idx_t;

    // Per-button events produced by one update.
    typedef struct packed {
        logic pressed;
        logic fresh;
        logic triple;
        logic single;
    } btn_flags_t;

endpackage

[rtl/core/bd3p_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button sample channel
// Carries one tick of raw active-low button levels.
// ----------------------------------------------------------------------------
interface bd3p_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink   (input valid, input raw_levels, output ready);
endinterface

[rtl/core/bd3p_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button result channel
// Carries the debounced levels and press events of one tick.
// ----------------------------------------------------------------------------
interface bd3p_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] pressed_levels;
    logic [2:0] new_press;
    logic [2:0] triple_press;
    logic [2:0] single_press;

    modport source (output valid, output pressed_levels, output new_press,
                    output triple_press, output single_press, input ready);
    modport sink   (input valid, input pressed_levels, input new_press,
                    input triple_press, input single_press, output ready);
endinterface

[rtl/core/bd3p_button_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button state update
// Debounce, press counting, triple check and single press expiry of one
// button, applied to its stored state entry.
// ----------------------------------------------------------------------------
module bd3p_button_update
    import bd3p_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ENTRY_W   = ENTRY_FIXED_W + 4 * TIME_BITS
)
(
    input  logic [TIME_BITS-1:0] now,
    input  logic                 reading,
    input  logic [CFG_W-1:0]     debounce_ms,
    input  logic [CFG_W-1:0]     min_press_gap_ms,
    input  logic [CFG_W-1:0]     press_window_ms,
    input  logic [ENTRY_W-1:0]   entry_old,
    output logic [ENTRY_W-1:0]   entry_new,
    output btn_flags_t           flags
);

    logic                 raw_prev;
    logic                 stable;
    logic                 pending;
    logic [COUNT_W-1:0]   count;
    logic [TIME_BITS-1:0] db_start;
    logic [TIME_BITS-1:0] first_time;
    logic [TIME_BITS-1:0] last_time;
    logic [TIME_BITS-1:0] pend_since;

    logic [TIME_BITS-1:0] db_start_1;
    logic [TIME_BITS-1:0] first_time_1;
    logic [TIME_BITS-1:0] last_time_1;
    logic [TIME_BITS-1:0] pend_since_1;
    logic [TIME_BITS-1:0] first_time_out;
    logic [COUNT_W-1:0]   count_1;
    logic [COUNT_W-1:0]   count_out;
    logic                 stable_1;
    logic                 pending_out;

    logic [TIME_BITS-1:0] win;
    logic                 raw_changed;
    logic                 settled;
    logic                 level_change;
    logic                 fresh;
    logic                 counted;
    logic                 in_window;
    logic                 in_window_1;
    logic                 pend_expired;
    logic                 triple_hit;
    logic                 triple_fire;
    logic                 expire_fire;

    assign {raw_prev, stable, pending, count,
            db_start, first_time, last_time, pend_since} = entry_old;

    assign win = TIME_BITS'(press_window_ms);

    // The subtractions wrap at TIME_BITS bits, which gives the elapsed time.
    always_comb
    begin
        raw_changed  = (reading != raw_prev);
        db_start_1   = raw_changed ? now : db_start;
        settled      = !raw_changed && ((now - db_start) > TIME_BITS'(debounce_ms));
        level_change = settled && (reading != stable);
        stable_1     = level_change ? reading : stable;
        fresh        = level_change && reading;
        counted      = fresh && ((now - last_time) > TIME_BITS'(min_press_gap_ms));
        in_window    = (now - first_time) <= win;

        count_1      = count;
        first_time_1 = first_time;
        if (counted)
        begin
            if (in_window)
            begin
                if (count < COUNT_MAX)
                begin
                    count_1 = count + COUNT_W'(1);
                end
            end
            else
            begin
                count_1      = COUNT_W'(1);
                first_time_1 = now;
            end
        end
        last_time_1  = counted ? now : last_time;
        pend_since_1 = counted ? now : pend_since;

        // A freshly started window is zero ticks old.
        in_window_1  = (counted && !in_window) ? 1'b1 : in_window;
        pend_expired = !counted && ((now - pend_since) > win);

        triple_hit  = (count_1 >= TRIPLE_COUNT);
        triple_fire = triple_hit && in_window_1;
        pending_out = (counted || pending) && !triple_fire;
        count_out      = triple_hit ? '0 : count_1;
        first_time_out = triple_hit ? '0 : first_time_1;

        expire_fire = pending_out && pend_expired;
        flags.single = expire_fire && (count_out < TRIPLE_COUNT);
        if (expire_fire)
        begin
            pending_out    = 1'b0;
            count_out      = '0;
            first_time_out = '0;
        end

        flags.pressed = stable_1;
        flags.fresh   = fresh;
        flags.triple  = triple_fire;

        entry_new = {reading, stable_1, pending_out, count_out,
                     db_start_1, first_time_out, last_time_1, pend_since_1};
    end

endmodule

[rtl/core/button_debounce_triple_press.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce triple press detector
// Debounces active-low buttons once per tick and reports new, triple and
// delayed single presses, keeping all per-button state in one memory.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   -------   ---------  ----------------------------------------------------
//   sample    sink       raw_levels: one tick of raw button pins, 0 = pressed
//   result    source     pressed_levels, new_press, triple_press, single_press
//   wr_*      write      wr_index selects a register, wr_data its new value
//
// A new sample beat is taken only when stage one is idle or issues the last
// button of the previous beat, since the state memory serves one button per
// cycle, when not stalled, through its single port.
// Reset clears one valid bit per memory entry; an unwritten entry reads as all
// zero, so no clearing pass is run and samples are taken right after reset.
// A result beat that is not taken stalls the pipeline only when the next
// result is ready to be written into the output register.
//
module button_debounce_triple_press
    import bd3p_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_ADDR_W-1:0] wr_index,
    input  logic [CFG_W-1:0]      wr_data,
    bd3p_in_if.sink               sample,
    bd3p_out_if.source            result
);

    `include "button_debounce_triple_press_assert.svh"

    localparam int IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int ENTRY_W = ENTRY_FIXED_W + 4 * TIME_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    // Configuration registers.
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] gap_reg;
    logic [CFG_W-1:0] window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            gap_reg      <= GAP_RESET;
            window_reg   <= WINDOW_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_DEBOUNCE: debounce_reg <= wr_data;
                REG_MIN_GAP:  gap_reg      <= wr_data;
                REG_WINDOW:   window_reg   <= wr_data;
                default:      ;
            endcase
        end
    end

    // Pipeline control. Stage one issues the memory read of one button;
    // stage two updates that button from the read data and writes it back.
    logic                 s1_valid_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic [OUT_BITS-1:0]  item_raw_reg;
    logic [TIME_BITS-1:0] item_now_reg;
    logic [TIME_BITS-1:0] tick_reg;
    logic [TIME_BITS-1:0] tick_next;

    logic                 s2_valid_reg;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic                 s2_reading_reg;
    logic [TIME_BITS-1:0] s2_now_reg;

    logic                 s1_last;
    logic                 s2_last;
    logic                 stall;
    logic                 accept;
    logic                 issue;
    logic                 write_back;
    logic [NUM_BUTTONS-1:0] reading_vec;

    assign s1_last    = (s1_idx_reg == LAST_IDX);
    assign s2_last    = (s2_idx_reg == LAST_IDX);
    // The final button of a tick needs a free output register.
    assign stall      = s2_valid_reg && s2_last && result.valid && !result.ready;
    assign sample.ready = !stall && (!s1_valid_reg || s1_last);
    assign accept     = sample.valid && sample.ready;
    assign issue      = s1_valid_reg && !stall;
    assign write_back = s2_valid_reg && !stall;
    assign tick_next  = tick_reg + TIME_BITS'(1);

    // Buttons past the sampled pins read as pressed.
    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (b < OUT_BITS)
            begin
                reading_vec[b] = !item_raw_reg[b];
            end
            else
            begin
                reading_vec[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_idx_reg   <= '0;
            tick_reg     <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_idx_reg   <= '0;
                tick_reg     <= tick_next;
            end
            else if (issue && s1_last)
            begin
                s1_valid_reg <= 1'b0;
            end
            else if (issue)
            begin
                s1_idx_reg <= s1_idx_reg + IDX_W'(1);
            end
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_raw_reg <= sample.raw_levels;
            item_now_reg <= tick_next;
        end
        if (issue)
        begin
            s2_idx_reg     <= s1_idx_reg;
            s2_reading_reg <= reading_vec[s1_idx_reg];
            s2_now_reg     <= item_now_reg;
        end
    end

    // State memory, one entry per button, read data registered.
    logic [ENTRY_W-1:0]     state_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] entry_vld_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_vld_reg;
    logic                   fwd_reg;
    logic [ENTRY_W-1:0]     fwd_data_reg;
    logic [ENTRY_W-1:0]     entry_old;
    logic [ENTRY_W-1:0]     entry_new;
    btn_flags_t             flags;

    always_ff @(posedge clk)
    begin
        if (write_back)
        begin
            state_mem[s2_idx_reg] <= entry_new;
        end
        if (issue)
        begin
            rd_data_reg  <= state_mem[s1_idx_reg];
            rd_vld_reg   <= entry_vld_reg[s1_idx_reg];
            fwd_data_reg <= entry_new;
        end
    end

    // Valid bits stand in for the zero reset of the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (write_back)
            begin
                entry_vld_reg[s2_idx_reg] <= 1'b1;
            end
            if (issue)
            begin
                // A read of the entry written back at the same edge sees the
                // old contents, so the new value is forwarded instead.
                fwd_reg <= write_back && (s2_idx_reg == s1_idx_reg);
            end
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            entry_old = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            entry_old = rd_data_reg;
        end
        else
        begin
            entry_old = '0;
        end
    end

    bd3p_button_update #(
        .TIME_BITS (TIME_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_update (
        .now              (s2_now_reg),
        .reading          (s2_reading_reg),
        .debounce_ms      (debounce_reg),
        .min_press_gap_ms (gap_reg),
        .press_window_ms  (window_reg),
        .entry_old        (entry_old),
        .entry_new        (entry_new),
        .flags            (flags)
    );

    // Result bits are gathered button by button; only the first three buttons
    // have a place in the result beat, the shift drops the rest.
    logic [OUT_BITS-1:0] btn_mask;
    logic [OUT_BITS-1:0] acc_pressed_reg;
    logic [OUT_BITS-1:0] acc_fresh_reg;
    logic [OUT_BITS-1:0] acc_triple_reg;
    logic [OUT_BITS-1:0] acc_single_reg;
    logic [OUT_BITS-1:0] acc_pressed_next;
    logic [OUT_BITS-1:0] acc_fresh_next;
    logic [OUT_BITS-1:0] acc_triple_next;
    logic [OUT_BITS-1:0] acc_single_next;
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_pressed_reg;
    logic [OUT_BITS-1:0] out_fresh_reg;
    logic [OUT_BITS-1:0] out_triple_reg;
    logic [OUT_BITS-1:0] out_single_reg;

    always_comb
    begin
        btn_mask = OUT_BITS'(1) << s2_idx_reg;
        if (s2_idx_reg == '0)
        begin
            acc_pressed_next = '0;
            acc_fresh_next   = '0;
            acc_triple_next  = '0;
            acc_single_next  = '0;
        end
        else
        begin
            acc_pressed_next = acc_pressed_reg;
            acc_fresh_next   = acc_fresh_reg;
            acc_triple_next  = acc_triple_reg;
            acc_single_next  = acc_single_reg;
        end
        if (flags.pressed)
        begin
            acc_pressed_next = acc_pressed_next | btn_mask;
        end
        if (flags.fresh)
        begin
            acc_fresh_next = acc_fresh_next | btn_mask;
        end
        if (flags.triple)
        begin
            acc_triple_next = acc_triple_next | btn_mask;
        end
        if (flags.single)
        begin
            acc_single_next = acc_single_next | btn_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_back)
        begin
            acc_pressed_reg <= acc_pressed_next;
            acc_fresh_reg   <= acc_fresh_next;
            acc_triple_reg  <= acc_triple_next;
            acc_single_reg  <= acc_single_next;
            if (s2_last)
            begin
                out_pressed_reg <= acc_pressed_next;
                out_fresh_reg   <= acc_fresh_next;
                out_triple_reg  <= acc_triple_next;
                out_single_reg  <= acc_single_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (write_back && s2_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.pressed_levels = out_pressed_reg;
    assign result.new_press      = out_fresh_reg;
    assign result.triple_press   = out_triple_reg;
    assign result.single_press   = out_single_reg;

    // An accepted sample starts its sweep at the first button.
    `BD3P_ASSERT_NEXT(a_sweep_start, accept, s1_valid_reg && (s1_idx_reg == '0), "sweep did not start at button zero")
    // Buttons of one tick reach the update stage in consecutive cycles.
    `BD3P_ASSERT_NEXT(a_sweep_order, write_back && !s2_last, s2_valid_reg && (s2_idx_reg == $past(s2_idx_reg) + IDX_W'(1)), "update stage skipped a button")
    // A result beat is raised only by the last button of a tick.
    `BD3P_ASSERT_SAME(a_result_source, $rose(out_valid_reg), $past(s2_valid_reg && s2_last), "result raised without a finished tick")

endmodule
